[design/bia_pkg.sv]
// Shared types and constants for the bitmap identifier allocator.
// No dependencies; used by bitmap_id_allocator and bia_map.
package bia_pkg;

  localparam int ID_W  = 10;
  localparam int ACT_W = 2;
  localparam int ST_W  = 3;

  localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

  localparam logic [ST_W-1:0] ST_ALLOC = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [ST_W-1:0] ST_FREED = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd3;
  localparam logic [ST_W-1:0] ST_INIT  = 3'd4;

  localparam logic [ID_W-1:0] POOL_RESET = 10'd1023;

  typedef struct packed {
    logic wr_en;
    logic init;
  } map_ctl_t;

endpackage

[design/bitmap_id_allocator.sv]
// Bitmap identifier allocator: sequencer over a one-port bitmap memory.
// Init passes through S_INIT; free steps S_FIND up to the word of free_id, then
// S_FMOD sets its bit; allocate scans active words, one word per cycle.
// One item at a time; a waiting result does not block the next accept.
// Synchronous reset: every identifier taken, search word 0, pool_size 1023.
module bitmap_id_allocator #(
  parameter int WORD_BITS = 32,
  parameter int NUM_WORDS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bia_pkg::ACT_W-1:0]  action,
  input  logic [bia_pkg::ID_W-1:0]   free_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bia_pkg::ID_W-1:0]   id,
  output logic [bia_pkg::ST_W-1:0]   status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bia_pkg::ID_W-1:0]   cfg_data
);

  localparam int AW       = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W    = $clog2(WORD_BITS);
  localparam int BW       = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam int CW       = (BW > bia_pkg::ID_W ? BW : bia_pkg::ID_W) + 1;
  localparam int MAP_BITS = NUM_WORDS * WORD_BITS;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_INIT  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_EMPTY = 8'b0000_1000,
    S_ALLOC = 8'b0001_0000,
    S_FIND  = 8'b0010_0000,
    S_FMOD  = 8'b0100_0000,
    S_RANGE = 8'b1000_0000
  } state_t;

  state_t                   state;
  logic [bia_pkg::ID_W-1:0] pool_size;
  logic [AW-1:0]            search_word;
  logic [AW-1:0]            cur_w;
  logic [AW-1:0]            start_w;
  logic [AW-1:0]            chk_w;
  logic                     chk_vld;
  logic                     chk_last;
  logic                     iss_done;
  logic [AW-1:0]            alloc_w;
  logic [WORD_BITS-1:0]     word_q;
  logic [bia_pkg::ID_W-1:0] fid_q;
  logic [CW-1:0]            fbase;

  bia_pkg::map_ctl_t        ctl;
  logic [AW-1:0]            wr_addr;
  logic [WORD_BITS-1:0]     wr_data;
  logic [WORD_BITS-1:0]     rd_word;
  logic [BIT_W-1:0]         low_idx;
  logic [WORD_BITS-1:0]     low_cleared;
  logic [WORD_BITS-1:0]     set_word;
  logic [BIT_W-1:0]         bit_off;
  logic [CW-1:0]            fdiff;
  logic [CW-1:0]            alloc_id;
  logic [AW-1:0]            nxt_w;
  logic [AW:0]              sw_inc;
  logic                     out_free;
  logic                     out_load;
  logic                     in_acc;

  function automatic logic active_word(input logic [AW:0] w,
                                       input logic [bia_pkg::ID_W-1:0] p);
    logic [CW-1:0] prod;
    prod = CW'(w) * CW'(WORD_BITS);
    return (w < (AW+1)'(NUM_WORDS)) && (prod <= CW'(p));
  endfunction

  function automatic logic [AW-1:0] next_word(input logic [AW-1:0] w,
                                              input logic [bia_pkg::ID_W-1:0] p);
    logic [AW:0] nw;
    nw = {1'b0, w} + (AW+1)'(1);
    return active_word(nw, p) ? nw[AW-1:0] : '0;
  endfunction

  bia_map #(
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .init_pool (pool_size),
    .rd_addr   (cur_w),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_word   (rd_word)
  );

  bia_lowbit #(
    .WORD_BITS (WORD_BITS)
  ) u_lowbit (
    .word    (word_q),
    .bit_idx (low_idx),
    .cleared (low_cleared)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && (state inside {S_INIT, S_EMPTY, S_ALLOC, S_FMOD, S_RANGE});

  always_comb begin
    fdiff   = CW'(fid_q) - fbase;
    bit_off = fdiff[BIT_W-1:0];
    for (int i = 0; i < WORD_BITS; i++) begin
      set_word[i] = rd_word[i] | (bit_off == BIT_W'(i));
    end
    alloc_id = CW'(alloc_w) * CW'(WORD_BITS) + CW'(low_idx);
    nxt_w    = next_word(cur_w, pool_size);
    sw_inc   = {1'b0, search_word} + (AW+1)'(1);
  end

  always_comb begin
    ctl.wr_en = 1'b0;
    ctl.init  = 1'b0;
    wr_addr   = cur_w;
    wr_data   = set_word;
    case (state)
      S_INIT: begin
        ctl.init = out_free;
      end
      S_ALLOC: begin
        ctl.wr_en = out_free;
        wr_addr   = alloc_w;
        wr_data   = low_cleared;
      end
      S_FMOD: begin
        ctl.wr_en = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pool_size   <= bia_pkg::POOL_RESET;
      search_word <= '0;
      out_valid   <= 1'b0;
      chk_vld     <= 1'b0;
      iss_done    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pool_size <= cfg_data;
      end
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (action)
              bia_pkg::ACT_INIT: begin
                state <= S_INIT;
              end
              bia_pkg::ACT_ALLOC: begin
                if (active_word({1'b0, search_word}, pool_size)) begin
                  cur_w   <= search_word;
                  start_w <= search_word;
                end else begin
                  cur_w   <= '0;
                  start_w <= '0;
                end
                chk_vld  <= 1'b0;
                iss_done <= 1'b0;
                state    <= S_SCAN;
              end
              bia_pkg::ACT_FREE: begin
                if (free_id >= pool_size || CW'(free_id) >= CW'(MAP_BITS)) begin
                  state <= S_RANGE;
                end else begin
                  fid_q <= free_id;
                  cur_w <= '0;
                  fbase <= '0;
                  state <= S_FIND;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_INIT: begin
          if (out_free) begin
            search_word <= '0;
            out_valid   <= 1'b1;
            id          <= '0;
            status      <= bia_pkg::ST_INIT;
            state       <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (chk_vld && rd_word != '0) begin
            word_q  <= rd_word;
            alloc_w <= chk_w;
            state   <= S_ALLOC;
          end else if (chk_vld && chk_last) begin
            state <= S_EMPTY;
          end else if (!iss_done) begin
            chk_vld  <= 1'b1;
            chk_w    <= cur_w;
            chk_last <= (nxt_w == start_w);
            iss_done <= (nxt_w == start_w);
            cur_w    <= nxt_w;
          end else begin
            chk_vld <= 1'b0;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_valid <= 1'b1;
            id        <= '0;
            status    <= bia_pkg::ST_EMPTY;
            state     <= S_IDLE;
          end
        end
        S_ALLOC: begin
          if (out_free) begin
            if (low_cleared == '0) begin
              search_word <= active_word(sw_inc, pool_size) ? sw_inc[AW-1:0] : '0;
            end
            out_valid <= 1'b1;
            id        <= alloc_id[bia_pkg::ID_W-1:0];
            status    <= bia_pkg::ST_ALLOC;
            state     <= S_IDLE;
          end
        end
        S_FIND: begin
          if (CW'(fid_q) < fbase + CW'(WORD_BITS)) begin
            state <= S_FMOD;
          end else begin
            cur_w <= cur_w + AW'(1);
            fbase <= fbase + CW'(WORD_BITS);
          end
        end
        S_FMOD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            id        <= '0;
            status    <= bia_pkg::ST_FREED;
            state     <= S_IDLE;
          end
        end
        S_RANGE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            id        <= '0;
            status    <= bia_pkg::ST_RANGE;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/bia_map.sv]
// Free bitmap storage: word memory, per-word valid bits and init pattern.
// Depends on bia_pkg for the control struct and identifier width.
module bia_map #(
  parameter int WORD_BITS = 32,
  parameter int NUM_WORDS = 32,
  parameter int AW        = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bia_pkg::map_ctl_t         ctl,
  input  logic [bia_pkg::ID_W-1:0]  init_pool,
  input  logic [AW-1:0]             rd_addr,
  input  logic [AW-1:0]             wr_addr,
  input  logic [WORD_BITS-1:0]      wr_data,
  output logic [WORD_BITS-1:0]      rd_word
);

  localparam int BW = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam int CW = (BW > bia_pkg::ID_W ? BW : bia_pkg::ID_W) + 1;

  logic [WORD_BITS-1:0]     mem [NUM_WORDS];
  logic [NUM_WORDS-1:0]     vld;
  logic [WORD_BITS-1:0]     rdata;
  logic                     rd_vld;
  logic [AW-1:0]            rd_addr_q;
  logic [bia_pkg::ID_W-1:0] pool_q;
  logic [CW-1:0]            base;
  logic [CW-1:0]            pool_ext;
  logic [CW-1:0]            rem;
  logic [WORD_BITS-1:0]     pat;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata     <= mem[rd_addr];
    rd_vld    <= vld[rd_addr];
    rd_addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      pool_q <= '0;
    end else if (ctl.init) begin
      vld    <= '0;
      pool_q <= init_pool;
    end else if (ctl.wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    base     = CW'(rd_addr_q) * CW'(WORD_BITS);
    pool_ext = CW'(pool_q);
    rem      = (pool_ext > base) ? (pool_ext - base) : '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      pat[i] = rem > CW'(i);
    end
  end

  assign rd_word = rd_vld ? rdata : pat;

endmodule

[design/bia_lowbit.sv]
// Lowest-set-bit finder: bit index and word with that bit cleared.
// No package dependencies.
module bia_lowbit #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0]         word,
  output logic [$clog2(WORD_BITS)-1:0] bit_idx,
  output logic [WORD_BITS-1:0]         cleared
);

  localparam int BIT_W = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] low;

  always_comb begin
    low     = word & (~word + WORD_BITS'(1));
    cleared = word & ~low;
    bit_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low[i]) begin
        bit_idx = bit_idx | BIT_W'(i);
      end
    end
  end

endmodule
